[src/ostt_pkg.sv]
// Package for the one-shot timer table: table size, derived widths,
// mode and result kind codes, and the sequencer state type.
// No dependencies.
package ostt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SLOT_W     = 4;
  localparam int WORD_W     = 32;
  localparam int TPS_W      = 10;
  localparam int BIT_CNT_W  = $clog2(WORD_W);

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(100);

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_CANCEL  = 2'd1;
  localparam logic [1:0] KIND_FIRE    = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN
  } ostt_state_t;

endpackage

[src/one_shot_timer_table.sv]
// One-shot timer table top level: slot bookkeeping, tick and seconds
// counters, a bit-serial remainder unit and the slot scan sequencer.
// Depends on ostt_pkg.
//
// Channel   Direction  Handshake           Payload
// input     in         start / busy        in_mode, in_delay_ticks, in_cancel_slot
// result    out        out_valid (strobe)  out_kind, out_slot, out_table_full,
//                                          out_tick_count, out_seconds_count, out_last
// config    in         cfg_we              cfg_wdata (ticks per second)
//
// A start or cancel word is taken while busy is low; its result shows on the next
// cycle and busy stays low, so these words can follow back to back.
// A tick word holds busy high while the bit-serial remainder unit (one
// dividend bit per cycle) decides the seconds bump, then while the registered
// expiry read is primed, each slot is compared in turn and a summary is
// formed. The summary is on the result ports in the first cycle that busy is
// low again.
// Reset is synchronous and active low; it frees all slots, zeroes both
// counters and restores ticks per second to 100. The expiry memory is not
// cleared, since an entry is read only for a slot that was claimed.
// The receiver cannot stall: each result is on the ports for one cycle only.
module one_shot_timer_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic [ostt_pkg::WORD_W-1:0]  in_delay_ticks,
  input  logic [ostt_pkg::SLOT_W-1:0]  in_cancel_slot,
  input  logic                         cfg_we,
  input  logic [ostt_pkg::TPS_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  output logic [1:0]                   out_kind,
  output logic [ostt_pkg::SLOT_W-1:0]  out_slot,
  output logic                         out_table_full,
  output logic [ostt_pkg::WORD_W-1:0]  out_tick_count,
  output logic [ostt_pkg::WORD_W-1:0]  out_seconds_count,
  output logic                         out_last
);
  import ostt_pkg::*;

  // Sequencer and counters.
  ostt_state_t              state_r, state_nxt;
  logic [NUM_TIMERS-1:0]    slot_busy_r, slot_busy_nxt;
  logic [WORD_W-1:0]        tick_r, tick_nxt;
  logic [WORD_W-1:0]        sec_r, sec_nxt;
  logic [TPS_W-1:0]         tps_r;

  // Remainder unit: the new tick count shifts out MSB first into rem_r.
  logic [WORD_W-1:0]        div_r, div_nxt;
  logic [TPS_W-1:0]         rem_r, rem_nxt;
  logic [BIT_CNT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [TPS_W-1:0]         tps_eff;
  logic [TPS_W:0]           trial;
  logic [TPS_W:0]           trial_diff;

  // Scan pipeline: read slot scan_idx_r while comparing slot cmp_idx_r.
  logic [CNT_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic [WORD_W-1:0]        rd_data_r;
  logic [WORD_W-1:0]        exp_diff;
  logic                     fire;

  // Expiry memory.
  logic [WORD_W-1:0]        expiry_mem [NUM_TIMERS];
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [WORD_W-1:0]        mem_wdata;

  // Free slot search and cancel decode.
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W-1:0]         cancel_idx;
  logic                     cancel_in_range;
  logic                     accept;

  // Result register.
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]        out_slot_r, out_slot_nxt;
  logic                     out_full_r, out_full_nxt;
  logic [WORD_W-1:0]        out_tick_r, out_tick_nxt;
  logic [WORD_W-1:0]        out_sec_r, out_sec_nxt;
  logic                     out_last_r, out_last_nxt;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!slot_busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign cancel_idx      = IDX_W'(in_cancel_slot);
  assign cancel_in_range = (32'(in_cancel_slot) < NUM_TIMERS);

  // One restoring step of the remainder; a zero rate counts as one.
  assign tps_eff    = (tps_r == '0) ? TPS_W'(1) : tps_r;
  assign trial      = {rem_r, div_r[WORD_W-1]};
  assign trial_diff = trial - {1'b0, tps_eff};

  // Wrap-safe expiry check: fired when expiry minus now is zero or negative.
  assign exp_diff = rd_data_r - tick_r;
  assign fire     = (exp_diff == '0) || exp_diff[WORD_W-1];

  assign mem_waddr = free_idx;
  assign mem_wdata = tick_r + in_delay_ticks;

  always_comb begin
    state_nxt     = state_r;
    slot_busy_nxt = slot_busy_r;
    tick_nxt      = tick_r;
    sec_nxt       = sec_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = scan_idx_r[IDX_W-1:0];
    mem_we        = 1'b0;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = KIND_START;
    out_slot_nxt  = '0;
    out_full_nxt  = 1'b0;
    out_tick_nxt  = tick_r;
    out_sec_nxt   = sec_r;
    out_last_nxt  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_START: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_START;
              out_last_nxt  = 1'b1;
              if (free_found) begin
                mem_we                  = 1'b1;
                slot_busy_nxt[free_idx] = 1'b1;
                out_slot_nxt            = SLOT_W'(free_idx);
              end else begin
                out_full_nxt = 1'b1;
              end
            end
            MODE_CANCEL: begin
              if (cancel_in_range) begin
                slot_busy_nxt[cancel_idx] = 1'b0;
              end
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_CANCEL;
              out_slot_nxt  = in_cancel_slot;
              out_last_nxt  = 1'b1;
            end
            MODE_TICK: begin
              tick_nxt    = tick_r + 1'b1;
              div_nxt     = tick_r + 1'b1;
              rem_nxt     = '0;
              bit_cnt_nxt = '0;
              state_nxt   = ST_MOD;
            end
            default: begin
              // Unused mode: no state change and no result.
            end
          endcase
        end
      end

      ST_MOD: begin
        rem_nxt     = trial_diff[TPS_W] ? trial[TPS_W-1:0] : trial_diff[TPS_W-1:0];
        div_nxt     = {div_r[WORD_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(WORD_W - 1)) begin
          if (rem_nxt == '0) begin
            sec_nxt = sec_r + 1'b1;
          end
          scan_idx_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        cmp_vld_nxt  = (scan_idx_r < CNT_W'(NUM_TIMERS));
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (cmp_vld_r && slot_busy_r[cmp_idx_r] && fire) begin
          slot_busy_nxt[cmp_idx_r] = 1'b0;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FIRE;
          out_slot_nxt  = SLOT_W'(cmp_idx_r);
        end
        // The last compare happened the cycle before; close with the summary.
        if (scan_idx_r == CNT_W'(NUM_TIMERS + 1)) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SUMMARY;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_busy_r <= '0;
      tick_r      <= '0;
      sec_r       <= '0;
      tps_r       <= TPS_RESET;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_busy_r <= slot_busy_nxt;
      tick_r      <= tick_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_full_r <= out_full_nxt;
    out_tick_r <= out_tick_nxt;
    out_sec_r  <= out_sec_nxt;
    out_last_r <= out_last_nxt;
  end

  // Expiry memory: one write port, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      expiry_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= expiry_mem[scan_idx_r[IDX_W-1:0]];
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_slot          = out_slot_r;
  assign out_table_full    = out_full_r;
  assign out_tick_count    = out_tick_r;
  assign out_seconds_count = out_sec_r;
  assign out_last          = out_last_r;

  // Fired timers are reported only from the slot scan.
  a_fire_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FIRE |-> $past(state_r) == ST_SCAN)
    else $error("timer fired outside the slot scan");

  // The summary closes a tick, so the block is ready again with it.
  a_summary_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUMMARY |-> !busy && out_last)
    else $error("tick summary without returning to idle");

  // A full answer is given only when every slot is taken.
  a_full_all_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> (&slot_busy_r))
    else $error("table full reported with a free slot");

  // Start and cancel words answer with a single final word on the next cycle.
  a_single_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode == MODE_START || in_mode == MODE_CANCEL)
    |=> out_valid && out_last && !busy)
    else $error("start or cancel word not answered in one cycle");

endmodule

[bench/tb.sv]
// Self-checking testbench for the one-shot timer table: directed words from a table,
// then random phases at several ticks-per-second settings, all checked against a predictor.
// Depends on ostt_pkg and one_shot_timer_table.
module tb;
  import ostt_pkg::*;

  // Mode 3 is not decoded by the block; it must be swallowed without a result.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  // Covers a whole tick word with room to spare.
  localparam int DRAIN_CYCLES = 60;
  localparam int NUM_PHASES = 7;
  localparam int WORDS_PER_PHASE = 50;

  // One result word as the block reports it.
  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic              full;
    logic [WORD_W-1:0] ticks;
    logic [WORD_W-1:0] secs;
    logic              last;
  } result_t;

  // One stimulus word. When typed is set, the kind, slot and full columns hold the
  // answer the block must give; the counters still come from the predictor.
  typedef struct packed {
    logic [1:0]        mode;
    logic [WORD_W-1:0] delay;
    logic [SLOT_W-1:0] cslot;
    logic              typed;
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic              full;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_mode;
  logic [WORD_W-1:0]   in_delay_ticks;
  logic [SLOT_W-1:0]   in_cancel_slot;
  logic                cfg_we;
  logic [TPS_W-1:0]    cfg_wdata;
  logic                out_valid;
  logic [1:0]          out_kind;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_table_full;
  logic [WORD_W-1:0]   out_tick_count;
  logic [WORD_W-1:0]   out_seconds_count;
  logic                out_last;

  one_shot_timer_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_delay_ticks    (in_delay_ticks),
    .in_cancel_slot    (in_cancel_slot),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_slot          (out_slot),
    .out_table_full    (out_table_full),
    .out_tick_count    (out_tick_count),
    .out_seconds_count (out_seconds_count),
    .out_last          (out_last)
  );

  // Shadow copy of the timer table, kept in step with every accepted word.
  logic              shadow_busy   [NUM_TIMERS];
  logic [WORD_W-1:0] shadow_expiry [NUM_TIMERS];
  logic [WORD_W-1:0] shadow_ticks;
  logic [WORD_W-1:0] shadow_secs;
  logic [TPS_W-1:0]  shadow_tps;

  // Results of the word being predicted, and all results still owed by the block.
  result_t step_results [$];
  result_t awaited_results [$];

  int mismatches;
  int cycle_count;
  int words_sent;
  int results_checked;
  int fires_seen;
  int full_answers;

  // The directed part. The sixteen starts fill the table in slot order, so their
  // slots can be read straight off; the seventeenth must come back full. The delays
  // hit the extremes: zero, one, all ones, the sign boundary on both sides.
  stim_row_t directed_rows [25] = '{
    '{MODE_TICK,   32'h0000_0000, 4'd0,  1'b0, KIND_SUMMARY, 4'd0,  1'b0},
    '{MODE_START,  32'h0000_0000, 4'd0,  1'b1, KIND_START,   4'd0,  1'b0},
    '{MODE_START,  32'h0000_0001, 4'd0,  1'b1, KIND_START,   4'd1,  1'b0},
    '{MODE_START,  32'hFFFF_FFFF, 4'd0,  1'b1, KIND_START,   4'd2,  1'b0},
    '{MODE_START,  32'h8000_0000, 4'd0,  1'b1, KIND_START,   4'd3,  1'b0},
    '{MODE_START,  32'h7FFF_FFFF, 4'd0,  1'b1, KIND_START,   4'd4,  1'b0},
    '{MODE_START,  32'h0000_0002, 4'd0,  1'b1, KIND_START,   4'd5,  1'b0},
    '{MODE_START,  32'h0000_0003, 4'd0,  1'b1, KIND_START,   4'd6,  1'b0},
    '{MODE_START,  32'h0000_0004, 4'd0,  1'b1, KIND_START,   4'd7,  1'b0},
    '{MODE_START,  32'h0000_0005, 4'd0,  1'b1, KIND_START,   4'd8,  1'b0},
    '{MODE_START,  32'h0000_0006, 4'd0,  1'b1, KIND_START,   4'd9,  1'b0},
    '{MODE_START,  32'h0000_0007, 4'd0,  1'b1, KIND_START,   4'd10, 1'b0},
    '{MODE_START,  32'h0000_0008, 4'd0,  1'b1, KIND_START,   4'd11, 1'b0},
    '{MODE_START,  32'hA5A5_A5A5, 4'd0,  1'b1, KIND_START,   4'd12, 1'b0},
    '{MODE_START,  32'h5A5A_5A5A, 4'd0,  1'b1, KIND_START,   4'd13, 1'b0},
    '{MODE_START,  32'h0000_0010, 4'd0,  1'b1, KIND_START,   4'd14, 1'b0},
    '{MODE_START,  32'h0000_0100, 4'd0,  1'b1, KIND_START,   4'd15, 1'b0},
    '{MODE_START,  32'h0000_0001, 4'd0,  1'b1, KIND_START,   4'd0,  1'b1},
    '{MODE_TICK,   32'h0000_0000, 4'd0,  1'b0, KIND_SUMMARY, 4'd0,  1'b0},
    '{MODE_CANCEL, 32'h0000_0000, 4'd15, 1'b1, KIND_CANCEL,  4'd15, 1'b0},
    '{MODE_CANCEL, 32'hFFFF_FFFF, 4'd15, 1'b1, KIND_CANCEL,  4'd15, 1'b0},
    '{MODE_UNUSED, 32'hFFFF_FFFF, 4'd15, 1'b0, KIND_SUMMARY, 4'd0,  1'b0},
    '{MODE_TICK,   32'h0000_0000, 4'd0,  1'b0, KIND_SUMMARY, 4'd0,  1'b0},
    '{MODE_START,  32'h0000_0000, 4'd0,  1'b1, KIND_START,   4'd0,  1'b0},
    '{MODE_TICK,   32'h0000_0000, 4'd0,  1'b0, KIND_SUMMARY, 4'd0,  1'b0}
  };

  // Free-running clock with a 20-unit period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Builds a result word around the shadow counters as they stand now.
  function automatic result_t timer_result(input logic [1:0] kind, input int slot,
                                           input logic full, input logic last);
    result_t r;
    r.kind  = kind;
    r.slot  = SLOT_W'(slot);
    r.full  = full;
    r.ticks = shadow_ticks;
    r.secs  = shadow_secs;
    r.last  = last;
    return r;
  endfunction

  // Applies one word to the shadow table and leaves its results in step_results.
  function automatic void predict_timer_word(input logic [1:0] mode,
                                             input logic [WORD_W-1:0] delay,
                                             input logic [SLOT_W-1:0] cslot);
    int claimed;
    logic [WORD_W-1:0] rate;
    logic [WORD_W-1:0] remaining;
    step_results.delete();
    case (mode)
      MODE_START: begin
        // The lowest free slot wins; a full table stores nothing.
        claimed = -1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!shadow_busy[i] && claimed < 0) claimed = i;
        end
        if (claimed >= 0) begin
          shadow_busy[claimed]   = 1'b1;
          shadow_expiry[claimed] = shadow_ticks + delay;
          step_results.push_back(timer_result(KIND_START, claimed, 1'b0, 1'b1));
        end else begin
          step_results.push_back(timer_result(KIND_START, 0, 1'b1, 1'b1));
        end
      end
      MODE_CANCEL: begin
        // Freeing a slot that is already free is harmless and still answered.
        shadow_busy[cslot] = 1'b0;
        step_results.push_back(timer_result(KIND_CANCEL, int'(cslot), 1'b0, 1'b1));
      end
      MODE_TICK: begin
        // A rate of zero behaves as one, so every tick bumps the seconds.
        rate = (shadow_tps == '0) ? WORD_W'(1) : WORD_W'(shadow_tps);
        shadow_ticks = shadow_ticks + 1;
        if (shadow_ticks % rate == '0) shadow_secs = shadow_secs + 1;
        // A timer is due when expiry minus now, read as signed, is not positive.
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (shadow_busy[i]) begin
            remaining = shadow_expiry[i] - shadow_ticks;
            if (remaining == '0 || remaining[WORD_W-1]) begin
              shadow_busy[i] = 1'b0;
              step_results.push_back(timer_result(KIND_FIRE, i, 1'b0, 1'b0));
            end
          end
        end
        step_results.push_back(timer_result(KIND_SUMMARY, 0, 1'b0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  // Presents one word at the falling edge and holds it until the block takes it.
  // The word is taken at the rising edge where start is high and busy is low; the
  // expected results are queued right there, so they are always in place before the
  // block can answer on the following cycle.
  task automatic send_word(input stim_row_t row);
    result_t patched;
    @(negedge clk);
    start          <= 1'b1;
    in_mode        <= row.mode;
    in_delay_ticks <= row.delay;
    in_cancel_slot <= row.cslot;
    do @(posedge clk); while (busy !== 1'b0);
    predict_timer_word(row.mode, row.delay, row.cslot);
    if (row.typed && step_results.size() != 0) begin
      patched      = step_results[0];
      patched.kind = row.kind;
      patched.slot = row.slot;
      patched.full = row.full;
      patched.last = 1'b1;
      step_results[0] = patched;
    end
    foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    words_sent++;
  endtask

  // Drops start for a random stretch: mostly none or a few cycles, now and then long.
  // With start held, the next word follows with no gap at all.
  task automatic pause_sender(input bit allow_gaps);
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (!allow_gaps || pick < 55) gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 3);
    else if (pick < 95) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 80);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Every strobed result is matched against the oldest one still owed. The outputs
  // are read at the rising edge that ends their cycle, before the block updates them.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing expected: kind %0d slot %0d", out_kind, out_slot);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("kind", WORD_W'(want.kind), WORD_W'(out_kind));
        compare_field("slot", WORD_W'(want.slot), WORD_W'(out_slot));
        compare_field("table_full", WORD_W'(want.full), WORD_W'(out_table_full));
        compare_field("tick_count", want.ticks, out_tick_count);
        compare_field("seconds_count", want.secs, out_seconds_count);
        compare_field("last", WORD_W'(want.last), WORD_W'(out_last));
        results_checked++;
        if (want.kind == KIND_FIRE) fires_seen++;
        if (want.full) full_answers++;
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("one_shot_timer_table test failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    logic [TPS_W-1:0] tps_plan [NUM_PHASES];
    int counted;
    int pick;
    int start_weight;
    bit allow_gaps;

    // Every input is known from time zero; reset is held low before the first word.
    rst_n          = 1'b0;
    start          = 1'b0;
    in_mode        = MODE_START;
    in_delay_ticks = '0;
    in_cancel_slot = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    mismatches     = 0;
    cycle_count    = 0;
    words_sent     = 0;
    results_checked = 0;
    fires_seen     = 0;
    full_answers   = 0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      shadow_busy[i]   = 1'b0;
      shadow_expiry[i] = '0;
    end
    shadow_ticks = '0;
    shadow_secs  = '0;
    shadow_tps   = TPS_RESET;

    // Rates to visit: both ends of the range, zero (treated as one), the top of the
    // field, two small rates that bump the seconds often, and one random rate.
    tps_plan[0] = TPS_W'(1);
    tps_plan[1] = TPS_W'(1000);
    tps_plan[2] = TPS_W'(0);
    tps_plan[3] = TPS_W'(3);
    tps_plan[4] = TPS_W'(1023);
    tps_plan[5] = TPS_W'(2);
    tps_plan[6] = TPS_W'($urandom_range(4, 999));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words run at the reset rate, which also checks the reset value.
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i]);
      pause_sender(1'b1);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // The rate only changes while the block is quiet: start is dropped before the
      // last word could be taken twice, all owed results are in, and a tick's worth
      // of cycles has passed in case the last word was unused.
      @(negedge clk);
      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= tps_plan[phase];
      @(negedge clk);
      cfg_we     <= 1'b0;
      shadow_tps  = tps_plan[phase];

      // Alternate phases lean on starts to push the table to full. Two phases run
      // with the sender never pausing.
      start_weight = (phase % 2 == 0) ? 55 : 35;
      allow_gaps   = !(phase == 2 || phase == 5);
      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        row   = '0;
        pick  = $urandom_range(0, 99);
        if (pick < start_weight) begin
          row.mode = MODE_START;
          pick = $urandom_range(0, 99);
          // Short delays keep timers firing; the rest span the whole word, and the
          // upper half lands behind the current count, so it fires on the next tick.
          if (pick < 65) row.delay = $urandom_range(0, 6);
          else if (pick < 75) row.delay = $urandom_range(7, 60);
          else if (pick < 90) row.delay = $urandom();
          else row.delay = 32'h8000_0000 | $urandom();
          row.cslot = SLOT_W'($urandom_range(0, 15));
        end else if (pick < start_weight + 20) begin
          // Half the cancels hunt for a busy slot so they actually free something.
          row.mode  = MODE_CANCEL;
          row.cslot = SLOT_W'($urandom_range(0, 15));
          if ($urandom_range(0, 1) == 1) begin
            for (int k = 0; k < NUM_TIMERS; k++) begin
              if (!shadow_busy[row.cslot]) row.cslot = row.cslot + 1'b1;
            end
          end
          row.delay = $urandom();
        end else if (pick < 95) begin
          row.mode  = MODE_TICK;
          row.delay = $urandom();
          row.cslot = SLOT_W'($urandom_range(0, 15));
        end else begin
          row.mode  = MODE_UNUSED;
          row.delay = $urandom();
          row.cslot = SLOT_W'($urandom_range(0, 15));
        end
        send_word(row);
        if (row.mode != MODE_UNUSED) counted++;
        pause_sender(allow_gaps);
      end
    end

    // Wait for every owed result, then let the block sit a while so a stray late
    // result would still be caught.
    @(negedge clk);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words over %0d rates; checked %0d results.",
             words_sent, NUM_PHASES + 1, results_checked);
    $display("Saw %0d timer fires and %0d full-table answers; final tick count %0d.",
             fires_seen, full_answers, shadow_ticks);
    if (mismatches == 0) begin
      $display("one_shot_timer_table test passed");
    end else begin
      $display("one_shot_timer_table test failed");
    end
    $finish;
  end

endmodule
